FILE: rtl/clt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_pkg: command line tokenizer shared definitions
// Constants, result and scanner state types, and the per-byte scan function.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int MAX_TOKENS = 1024;
    localparam int COUNT_W    = $clog2(MAX_TOKENS + 1);
    localparam int MAX_RES    = 4;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // scanner modes
    localparam logic [2:0] MODE_BETWEEN = 3'd0;
    localparam logic [2:0] MODE_TOKEN   = 3'd1;
    localparam logic [2:0] MODE_QUOTE   = 3'd2;
    localparam logic [2:0] MODE_COMMENT = 3'd3;
    localparam logic [2:0] MODE_DONE    = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_LINE = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [9:0]  index;
        logic [10:0] total;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [2:0]         mode;
        logic               slash;
        logic               star;
        logic [COUNT_W-1:0] count;
    } t_scan;

    typedef struct packed {
        t_scan      s;
        t_res [2:0] res;
        logic [1:0] n;
    } t_feed;

    function automatic t_feed f_emit(t_feed r_in, logic [1:0] kind, logic [7:0] data);
        t_feed r;
        t_res  e;
        r = r_in;
        e.kind  = kind;
        e.data  = (kind == KIND_BYTE) ? data : CH_NUL;
        e.index = (kind == KIND_LINE || r.s.count == '0) ? 10'd0
                                                          : 10'(r.s.count - 1'b1);
        e.total = (kind == KIND_LINE) ? 11'(r.s.count) : 11'd0;
        e.last  = 1'b0;
        if (r.n != 2'd3) begin
            r.res[r.n] = e;
            r.n        = r.n + 2'd1;
        end
        return r;
    endfunction

    function automatic t_feed f_line_end(t_feed r_in);
        t_feed r;
        r = f_emit(r_in, KIND_LINE, CH_NUL);
        r.s.mode  = MODE_DONE;
        r.s.slash = 1'b0;
        r.s.star  = 1'b0;
        return r;
    endfunction

    function automatic t_feed f_end_token(t_feed r_in);
        t_feed r;
        r = f_emit(r_in, KIND_END, CH_NUL);
        if (r.s.count >= COUNT_W'(MAX_TOKENS)) begin
            r = f_line_end(r);
        end else begin
            r.s.mode = MODE_BETWEEN;
        end
        return r;
    endfunction

    function automatic t_feed f_start_token(t_feed r_in, logic [2:0] mode);
        t_feed r;
        r = r_in;
        if (r.s.count < COUNT_W'(MAX_TOKENS)) begin
            r.s.count = r.s.count + 1'b1;
        end
        r.s.mode = mode;
        return r;
    endfunction

    // One byte through the scanner: next state and up to three results.
    function automatic t_feed f_feed(t_scan s, logic [7:0] b, logic ign_q);
        t_feed r;
        logic  go;
        logic  sep;
        logic  quote;
        r     = '0;
        r.s   = s;
        go    = (s.mode != MODE_DONE);
        sep   = (b <= CH_SPACE) || b[7];
        quote = !ign_q && (b == CH_QUOTE);
        if (go && s.slash) begin
            r.s.slash = 1'b0;
            if (s.mode == MODE_BETWEEN) begin
                if (b == CH_SLASH) begin
                    r  = f_line_end(r);
                    go = 1'b0;
                end else if (b == CH_STAR) begin
                    r.s.mode = MODE_COMMENT;
                    r.s.star = 1'b1;
                    go       = 1'b0;
                end else begin
                    r = f_start_token(r, MODE_TOKEN);
                    r = f_emit(r, KIND_BYTE, CH_SLASH);
                end
            end else begin
                if (b == CH_SLASH || b == CH_STAR) begin
                    r  = f_end_token(r);
                    go = 1'b0;
                    if (r.s.mode != MODE_DONE) begin
                        if (b == CH_SLASH) begin
                            r = f_line_end(r);
                        end else begin
                            r.s.mode = MODE_COMMENT;
                            r.s.star = 1'b1;
                        end
                    end
                end else begin
                    r = f_emit(r, KIND_BYTE, CH_SLASH);
                end
            end
        end
        if (go) begin
            unique case (r.s.mode)
                MODE_BETWEEN: begin
                    if (b == CH_NUL) begin
                        r = f_line_end(r);
                    end else if (sep) begin
                        r = r;
                    end else if (b == CH_SLASH) begin
                        r.s.slash = 1'b1;
                    end else if (quote) begin
                        r = f_start_token(r, MODE_QUOTE);
                    end else begin
                        r = f_start_token(r, MODE_TOKEN);
                        r = f_emit(r, KIND_BYTE, b);
                    end
                end
                MODE_TOKEN: begin
                    if (b == CH_NUL) begin
                        r = f_emit(r, KIND_END, CH_NUL);
                        r = f_line_end(r);
                    end else if (sep) begin
                        r = f_end_token(r);
                    end else if (b == CH_SLASH) begin
                        r.s.slash = 1'b1;
                    end else if (quote) begin
                        r = f_end_token(r);
                        if (r.s.mode != MODE_DONE) begin
                            r = f_start_token(r, MODE_QUOTE);
                        end
                    end else begin
                        r = f_emit(r, KIND_BYTE, b);
                    end
                end
                MODE_QUOTE: begin
                    if (b == CH_NUL) begin
                        r = f_emit(r, KIND_END, CH_NUL);
                        r = f_line_end(r);
                    end else if (b == CH_QUOTE) begin
                        r = f_end_token(r);
                    end else begin
                        r = f_emit(r, KIND_BYTE, b);
                    end
                end
                MODE_COMMENT: begin
                    if (b == CH_NUL) begin
                        r = f_line_end(r);
                    end else if (r.s.star && b == CH_SLASH) begin
                        r.s.star = 1'b0;
                        r.s.mode = MODE_BETWEEN;
                    end else begin
                        r.s.star = (b == CH_STAR);
                    end
                end
                default: begin
                    r.s.mode = MODE_DONE;
                end
            endcase
        end
        return r;
    endfunction

endpackage

FILE: rtl/command_line_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit: streaming command line tokenizer
// Splits a byte stream into tokens and reports token bytes, token ends and
// the line end with the token count, through an eight-entry result queue.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle unless the input stalls. A byte is held in
// the input register until it is scanned in a single pass that updates the
// scanner state and writes zero to four results into an eight-entry result
// queue, from which the results are offered at the output. Results leave one
// per cycle while the receiver is ready, so the sustained rate is one byte per
// cycle as long as the bytes average at most one result each; the input stalls
// while the queue has fewer than four free entries and a byte is waiting to be
// scanned.
module command_line_tokenizer_unit
    import clt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [9:0]  o_token_index,
    output logic [10:0] o_token_total,
    output logic        o_last_result
);

    logic              r_ign_q;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    t_scan             r_scan;
    t_scan             n_scan;
    t_res              r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FCNT_W-1:0] r_count;

    t_feed             w_f1;
    t_feed             w_f2;
    t_res              w_slot [MAX_RES];
    logic [2:0]        w_n;
    logic              w_proc;
    logic              w_pop;
    logic [2:0]        w_idx;

    assign o_cfg_ready = 1'b1;
    assign w_proc      = r_in_valid && (r_count <= FCNT_W'(FIFO_DEPTH - MAX_RES));
    assign o_in_ready  = !r_in_valid || w_proc;
    assign w_pop       = o_out_valid && i_out_ready;

    // scan the held byte, then the implied zero on the last byte of a line
    always_comb begin
        w_f1 = f_feed(r_scan, r_in_byte, r_ign_q);
        w_f2 = f_feed(w_f1.s, CH_NUL, r_ign_q);
        if (!r_in_last) begin
            w_f2.n = 2'd0;
        end
        w_n = 3'(w_f1.n) + 3'(w_f2.n);
        if (w_n > 3'(MAX_RES)) begin
            w_n = 3'(MAX_RES);
        end
        if (r_in_last) begin
            n_scan = '0;
            n_scan.mode = MODE_BETWEEN;
        end else begin
            n_scan = w_f1.s;
        end
        for (int k = 0; k < MAX_RES; k++) begin
            w_idx = 3'(k) - 3'(w_f1.n);
            if (3'(k) < 3'(w_f1.n)) begin
                w_slot[k] = w_f1.res[k[1:0]];
            end else if (w_idx < 3'd3) begin
                w_slot[k] = w_f2.res[w_idx[1:0]];
            end else begin
                w_slot[k] = '0;
            end
            w_slot[k].last = (3'(k) == w_n - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ign_q    <= 1'b0;
            r_in_valid <= 1'b0;
            r_scan     <= '{mode: MODE_BETWEEN, slash: 1'b0, star: 1'b0, count: '0};
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_ign_q <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_proc) begin
                r_scan   <= n_scan;
                r_wr_ptr <= r_wr_ptr + PTR_W'(w_n);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (w_proc ? FCNT_W'(w_n) : '0) - FCNT_W'(w_pop);
        end
    end

    // payload: input hold register and queue entries
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_last_byte;
        end
        if (w_proc) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (3'(k) < w_n) begin
                    r_fifo[r_wr_ptr + PTR_W'(k)] <= w_slot[k];
                end
            end
        end
    end

    assign o_out_valid   = (r_count != '0);
    assign o_kind        = r_fifo[r_rd_ptr].kind;
    assign o_out_byte    = r_fifo[r_rd_ptr].data;
    assign o_token_index = r_fifo[r_rd_ptr].index;
    assign o_token_total = r_fifo[r_rd_ptr].total;
    assign o_last_result = r_fifo[r_rd_ptr].last;

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FCNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_room_on_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |-> (r_count + FCNT_W'(w_n) <= FCNT_W'(FIFO_DEPTH)))
        else $error("scan wrote past free queue entries");

    a_line_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in_last) |=> (r_scan.mode == MODE_BETWEEN && r_scan.count == '0
                                   && !r_scan.slash))
        else $error("scanner not reset after last byte");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == KIND_BYTE || o_kind == KIND_END || o_kind == KIND_LINE))
        else $error("illegal result kind");

    a_line_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_LINE) |-> (o_out_byte == '0 && o_token_index == '0
                                                  && o_last_result))
        else $error("line end result fields wrong");

endmodule
